### hw/rtl/tgce_pkg.sv
// Shared types and constants for the tile grid collision editor.
// Grid geometry, command codes, request/result structs and the RAM write bundle.
// No dependencies.
package tgce_pkg;

	localparam int MAX_ROWS     = 64;
	localparam int MAX_COLS     = 256;
	localparam int TILE_SIZE    = 16;
	localparam int TILE_ID_BITS = 8;

	localparam int TILE_SHIFT = $clog2(TILE_SIZE);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int ADDR_W     = ROW_W + COL_W;
	localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;

	localparam int POS_W  = 16;
	localparam int SIZE_W = 12;
	// signed tile coordinate: pixel sum (POS_W+1 bits) shifted down, plus room for counts
	localparam int COORD_W = POS_W + 2 - TILE_SHIFT;

	localparam int ROW_COUNT_W = 7;
	localparam int COL_COUNT_W = 9;
	localparam int CFG_DATA_W  = 9;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

	localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = ROW_COUNT_W'(64);
	localparam logic [COL_COUNT_W-1:0] COL_COUNT_RST = COL_COUNT_W'(256);

	localparam logic [TILE_ID_BITS-1:0] BLOCK_ID  = TILE_ID_BITS'(53);
	localparam logic [TILE_ID_BITS-1:0] TILE_EMPTY = '0;

	typedef enum logic [1:0] {
		CMD_QUERY   = 2'd0,
		CMD_DESTROY = 2'd1,
		CMD_BUILD   = 2'd2,
		CMD_WRITE   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                    command;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [SIZE_W-1:0]       width;
		logic [SIZE_W-1:0]       height;
		logic [ROW_W-1:0]        load_row;
		logic [COL_W-1:0]        load_col;
		logic [TILE_ID_BITS-1:0] load_value;
	} req_t;

	typedef struct packed {
		logic hit;
		logic changed;
		logic out_of_range;
	} rsp_t;

	// decoded request: query span and single-cell target
	typedef struct packed {
		logic             empty;
		logic [COL_W-1:0] left;
		logic [COL_W-1:0] right;
		logic [ROW_W-1:0] top;
		logic [ROW_W-1:0] bottom;
		logic             oor;
		logic [ROW_W-1:0] pt_row;
		logic [COL_W-1:0] pt_col;
	} dec_t;

	typedef struct packed {
		logic                    we;
		logic [ADDR_W-1:0]       addr;
		logic [TILE_ID_BITS-1:0] data;
	} ram_wr_t;

endpackage

### hw/rtl/tgce_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tgce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/tgce_decode.sv
// Request decode: tile span of a query rectangle clamped to the grid in use,
// and the target cell of destroy/build/write with its range check. Uses tgce_pkg.
module tgce_decode (
	input  tgce_pkg::req_t                         req,
	input  logic [tgce_pkg::ROW_COUNT_W-1:0]       row_count,
	input  logic [tgce_pkg::COL_COUNT_W-1:0]       col_count,
	output tgce_pkg::dec_t                         dec
);
	import tgce_pkg::*;

	logic [ROW_COUNT_W-1:0]    nr;
	logic [COL_COUNT_W-1:0]    nc;
	logic signed [COORD_W-1:0] nrs, ncs;
	logic signed [POS_W:0]     x_end, y_end;
	logic signed [COORD_W-1:0] left_s, right_s, top_s, bottom_s;
	logic signed [COORD_W-1:0] left_c, right_c, top_c, bottom_c;
	logic                      pt_oor, wr_oor;

	always_comb begin
		nr  = (row_count > ROW_COUNT_W'(MAX_ROWS)) ? ROW_COUNT_W'(MAX_ROWS) : row_count;
		nc  = (col_count > COL_COUNT_W'(MAX_COLS)) ? COL_COUNT_W'(MAX_COLS) : col_count;
		nrs = $signed(COORD_W'(nr));
		ncs = $signed(COORD_W'(nc));

		// x+w and y+h are inclusive edges; arithmetic shift gives floor division
		x_end = $signed({req.pos_x[POS_W-1], req.pos_x})
			+ $signed({{(POS_W+1-SIZE_W){1'b0}}, req.width});
		y_end = $signed({req.pos_y[POS_W-1], req.pos_y})
			+ $signed({{(POS_W+1-SIZE_W){1'b0}}, req.height});

		left_s   = COORD_W'(req.pos_x >>> TILE_SHIFT);
		top_s    = COORD_W'(req.pos_y >>> TILE_SHIFT);
		right_s  = COORD_W'(x_end >>> TILE_SHIFT);
		bottom_s = COORD_W'(y_end >>> TILE_SHIFT);

		left_c   = (left_s < 0) ? '0 : left_s;
		top_c    = (top_s < 0) ? '0 : top_s;
		right_c  = (right_s >= ncs) ? ncs - COORD_W'(1) : right_s;
		bottom_c = (bottom_s >= nrs) ? nrs - COORD_W'(1) : bottom_s;

		dec.empty  = (left_c > right_c) || (top_c > bottom_c);
		dec.left   = left_c[COL_W-1:0];
		dec.right  = right_c[COL_W-1:0];
		dec.top    = top_c[ROW_W-1:0];
		dec.bottom = bottom_c[ROW_W-1:0];

		pt_oor = (left_s < 0) || (top_s < 0) || (left_s >= ncs) || (top_s >= nrs);
		wr_oor = (ROW_COUNT_W'(req.load_row) >= nr) || (COL_COUNT_W'(req.load_col) >= nc);

		if (req.command == CMD_WRITE) begin
			dec.oor    = wr_oor;
			dec.pt_row = req.load_row;
			dec.pt_col = req.load_col;
		end else begin
			dec.oor    = pt_oor;
			dec.pt_row = top_s[ROW_W-1:0];
			dec.pt_col = left_s[COL_W-1:0];
		end
	end

endmodule

### hw/rtl/tgce_ctrl.sv
// Sequencer: post-reset clearing pass, query span scan with one grid read per
// cycle, and read-modify-write of a single tile. Uses tgce_pkg.
module tgce_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  tgce_pkg::req_t                  req,
	output logic                            busy,
	output logic                            done,
	output tgce_pkg::rsp_t                  rsp,
	output tgce_pkg::req_t                  req_q,
	input  tgce_pkg::dec_t                  dec,
	output tgce_pkg::ram_wr_t               ram_wr,
	output logic [tgce_pkg::ADDR_W-1:0]     ram_raddr,
	input  logic [tgce_pkg::TILE_ID_BITS-1:0] ram_rdata
);
	import tgce_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_ISSUE  = 5'b00100,
		S_SCAN   = 5'b01000,
		S_MODIFY = 5'b10000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] addr_q;
	logic [COL_W-1:0]  cur_c_q, right_q;
	logic [ROW_W-1:0]  cur_r_q, top_q, bottom_q;
	logic              iss_done_q;
	logic              rd_vld_s1;
	logic              done_q;
	rsp_t              rsp_q;

	logic                    tile_nz;
	logic                    mod_we;
	logic [TILE_ID_BITS-1:0] mod_data;
	logic                    scan_hit, scan_end;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign tile_nz  = (ram_rdata != TILE_EMPTY);
	assign scan_hit = rd_vld_s1 && tile_nz;
	assign scan_end = iss_done_q && !rd_vld_s1;

	always_comb begin
		mod_we   = 1'b0;
		mod_data = TILE_EMPTY;
		case (req_q.command)
			CMD_DESTROY: begin
				mod_we   = tile_nz;
				mod_data = TILE_EMPTY;
			end
			CMD_BUILD: begin
				mod_we   = !tile_nz;
				mod_data = BLOCK_ID;
			end
			CMD_WRITE: begin
				mod_we   = (ram_rdata != req_q.load_value);
				mod_data = req_q.load_value;
			end
			default: begin
				mod_we   = 1'b0;
				mod_data = TILE_EMPTY;
			end
		endcase
	end

	always_comb begin
		ram_wr.we   = 1'b0;
		ram_wr.addr = addr_q;
		ram_wr.data = mod_data;
		if (state_q == S_CLEAR) begin
			ram_wr.we   = 1'b1;
			ram_wr.addr = clr_q;
			ram_wr.data = TILE_EMPTY;
		end else if (state_q == S_MODIFY) begin
			ram_wr.we = mod_we;
		end
		ram_raddr = (state_q == S_SCAN) ? {cur_r_q, cur_c_q} : {dec.pt_row, dec.pt_col};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			iss_done_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(GRID_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					case (req_q.command) inside
						CMD_QUERY: begin
							if (dec.empty) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else begin
								cur_c_q    <= dec.left;
								cur_r_q    <= dec.top;
								right_q    <= dec.right;
								top_q      <= dec.top;
								bottom_q   <= dec.bottom;
								iss_done_q <= 1'b0;
								rd_vld_s1  <= 1'b0;
								state_q    <= S_SCAN;
							end
						end
						CMD_DESTROY, CMD_BUILD, CMD_WRITE: begin
							addr_q <= {dec.pt_row, dec.pt_col};
							if (dec.oor) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else begin
								// tile read issued this cycle
								state_q <= S_MODIFY;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_SCAN: begin
					if (scan_hit || scan_end) begin
						state_q   <= S_IDLE;
						done_q    <= 1'b1;
						rd_vld_s1 <= 1'b0;
					end else begin
						rd_vld_s1 <= !iss_done_q;
						if (!iss_done_q) begin
							// column-major walk over the span
							if (cur_r_q == bottom_q) begin
								cur_r_q <= top_q;
								if (cur_c_q == right_q) begin
									iss_done_q <= 1'b1;
								end else begin
									cur_c_q <= cur_c_q + COL_W'(1);
								end
							end else begin
								cur_r_q <= cur_r_q + ROW_W'(1);
							end
						end
					end
				end
				S_MODIFY: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == S_ISSUE) begin
			rsp_q.hit          <= 1'b0;
			rsp_q.changed      <= 1'b0;
			rsp_q.out_of_range <= (req_q.command != CMD_QUERY) && dec.oor;
		end else if (state_q == S_SCAN) begin
			rsp_q.hit          <= scan_hit;
			rsp_q.changed      <= 1'b0;
			rsp_q.out_of_range <= 1'b0;
		end else if (state_q == S_MODIFY) begin
			rsp_q.hit          <= 1'b0;
			rsp_q.changed      <= mod_we;
			rsp_q.out_of_range <= 1'b0;
		end
	end

endmodule

### hw/rtl/tile_grid_collision_editor_unit.sv
// Top level of the tile grid collision editor: configuration registers, grid RAM,
// request decode and sequencer. Uses tgce_pkg, tgce_ram, tgce_decode, tgce_ctrl.
//
// Usage:
//  Request channel: a request (struct req) is taken at a rising edge with start high
//  and busy low. Commands: collision query, destroy block, build block, write tile.
//  Result channel: done pulses for one cycle with the result struct rsp valid in
//  that cycle; the receiver cannot stall it and must take it then.
//  Config channel: cfg_valid/cfg_ready with cfg_index (0 row_count, 1 col_count)
//  and cfg_data; cfg_ready is always high. Write only while no request is pending.
// Sequence (start accepted to done):
//  Out-of-range point or write, or a query with an empty span: ends after decode.
//  Destroy, build, write: decode and read, then modify and write back.
//  Query: the span is scanned with one grid RAM read per cycle, and the scan ends
//  early when a solid tile is found.
//  One request in flight at a time; busy drops in the cycle done pulses.
// Reset: counts return to 64 rows and 256 columns, then a clearing pass writes
//  every grid entry to empty, one per cycle, with busy high.
module tile_grid_collision_editor_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  tgce_pkg::req_t                 req,
	output logic                           busy,
	output logic                           done,
	output tgce_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tgce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tgce_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tgce_pkg::*;

	logic [ROW_COUNT_W-1:0]  row_count_q;
	logic [COL_COUNT_W-1:0]  col_count_q;
	req_t                    req_q;
	dec_t                    dec;
	ram_wr_t                 ram_wr;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [TILE_ID_BITS-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROW_COUNT: row_count_q <= cfg_data[ROW_COUNT_W-1:0];
				CFG_COL_COUNT: col_count_q <= cfg_data[COL_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	tgce_decode u_decode (
		.req       (req_q),
		.row_count (row_count_q),
		.col_count (col_count_q),
		.dec       (dec)
	);

	tgce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.req_q     (req_q),
		.dec       (dec),
		.ram_wr    (ram_wr),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	tgce_ram #(
		.WIDTH (TILE_ID_BITS),
		.DEPTH (GRID_DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### hw/rtl/tgce_chk.sv
// Port-level checker for the tile grid collision editor, bound to the top level.
// Uses tgce_pkg.
module tgce_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input tgce_pkg::rsp_t                 rsp,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);
	import tgce_pkg::*;

	// an accepted request keeps the block busy until its result
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after a request was accepted");

	// a result comes only at the end of a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside the end of a request");

	// one result per request: never two strobes in a row
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// at most one result flag is set: hit, changed and out_of_range exclude each other
	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!(rsp.hit && (rsp.changed || rsp.out_of_range))
			&& !(rsp.changed && rsp.out_of_range)))
		else $error("result flags inconsistent");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind tile_grid_collision_editor_unit tgce_chk u_tgce_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.rsp       (rsp),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
